>>> hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, disabled while reset is high
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define ASSERT_PROP_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bls_pkg.sv
// shared constants and width helpers for the line stepper
// no dependencies
package bls_pkg;

   // default canvas coordinate width
   localparam int COORD_BITS_DEF = 6;

   // number of classified commands held between front and back
   localparam int CMD_QUEUE_DEPTH = 2;

   // signed error term width for a given coordinate width
   function automatic int err_bits(input int cb);
      return cb + 3;
   endfunction

   // packed width of one classified command
   function automatic int cmd_bits(input int cb);
      return 4 * cb + 2 * err_bits(cb) + 3;
   endfunction

endpackage

>>> hdl/bls_setup.sv
// front end: takes a line command and classifies it for the stepper
// depends on bls_pkg
module bls_setup #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic                                       req_push,
   output logic                                       req_full,
   input  logic [COORD_BITS-1:0]                      start_x,
   input  logic [COORD_BITS-1:0]                      start_y,
   input  logic [COORD_BITS-1:0]                      end_x,
   input  logic [COORD_BITS-1:0]                      end_y,
   output logic                                       q_push,
   input  logic                                       q_full,
   output logic [bls_pkg::cmd_bits(COORD_BITS)-1:0]   cmd_word
);
   import bls_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int EB = err_bits(CB);

   typedef struct packed {
      logic                 x_major;
      logic                 min_down;
      logic [CB-1:0]        maj_pos;
      logic [CB-1:0]        min_pos;
      logic [CB-1:0]        span;
      logic signed [EB-1:0] err;
      logic [CB:0]          inc_keep;
      logic signed [EB-1:0] inc_take;
   } cmd_type;

   logic [CB-1:0] span_x;
   logic [CB-1:0] span_y;
   logic          x_major;
   logic [CB-1:0] maj0, maj1, min0, min1;
   logic [CB-1:0] maj_start, min_start, min_stop;
   logic          swap;
   logic [CB-1:0] maj_span;
   logic [CB-1:0] min_span;
   cmd_type       cmd;

   // handshake goes straight through to the command queue
   assign q_push   = req_push;
   assign req_full = q_full;

   // spans and major axis choice; equal spans go to y
   assign span_x  = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
   assign span_y  = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
   assign x_major = (span_x > span_y);

   // map endpoints onto major / minor axes
   assign maj0 = x_major ? start_x : start_y;
   assign min0 = x_major ? start_y : start_x;
   assign maj1 = x_major ? end_x   : end_y;
   assign min1 = x_major ? end_y   : end_x;

   // step from the smaller major coordinate
   assign swap      = (maj1 < maj0);
   assign maj_start = swap ? maj1 : maj0;
   assign min_start = swap ? min1 : min0;
   assign min_stop  = swap ? min0 : min1;

   assign maj_span = x_major ? span_x : span_y;
   assign min_span = x_major ? span_y : span_x;

   // initial decision value and the two per-step increments
   always_comb begin
      cmd.x_major  = x_major;
      cmd.min_down = (min_stop < min_start);
      cmd.maj_pos  = maj_start;
      cmd.min_pos  = min_start;
      cmd.span     = maj_span;
      cmd.err      = $signed({2'b00, min_span, 1'b0}) - $signed({3'b000, maj_span});
      cmd.inc_keep = {min_span, 1'b0};
      cmd.inc_take = $signed({2'b00, min_span, 1'b0}) - $signed({2'b00, maj_span, 1'b0});
   end

   assign cmd_word = cmd;

endmodule

>>> hdl/bls_cmd_queue.sv
// short queue of classified commands between front and back
// depends on bls_pkg
module bls_cmd_queue #(
   parameter int WIDTH = bls_pkg::cmd_bits(bls_pkg::COORD_BITS_DEF),
   parameter int DEPTH = bls_pkg::CMD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);
   import bls_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage slots, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> hdl/bls_stepper.sv
// back end: walks one classified line, one pixel per transfer
// depends on bls_pkg
module bls_stepper #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     q_empty,
   input  logic [bls_pkg::cmd_bits(COORD_BITS)-1:0] q_word,
   output logic                                     q_pop,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic [COORD_BITS-1:0]                    point_x,
   output logic [COORD_BITS-1:0]                    point_y,
   output logic                                     last_point
);
   import bls_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int EB = err_bits(CB);

   typedef struct packed {
      logic                 x_major;
      logic                 min_down;
      logic [CB-1:0]        maj_pos;
      logic [CB-1:0]        min_pos;
      logic [CB-1:0]        span;
      logic signed [EB-1:0] err;
      logic [CB:0]          inc_keep;
      logic signed [EB-1:0] inc_take;
   } cmd_type;

   cmd_type q_cmd;

   logic                 busy_ff, busy_in;
   logic                 x_major_ff, x_major_in;
   logic                 min_down_ff, min_down_in;
   logic [CB-1:0]        maj_ff, maj_in;
   logic [CB-1:0]        min_ff, min_in;
   logic [CB-1:0]        left_ff, left_in;
   logic signed [EB-1:0] err_ff, err_in;
   logic [CB:0]          inc_keep_ff, inc_keep_in;
   logic signed [EB-1:0] inc_take_ff, inc_take_in;

   logic advance;
   logic finishing;
   logic load;
   logic take;

   assign q_cmd = cmd_type'(q_word);

   // one pixel leaves per transfer; a new line loads when idle or on the last pixel
   assign advance   = busy_ff && rsp_pop;
   assign finishing = advance && (left_ff == '0);
   assign load      = !q_empty && (!busy_ff || finishing);
   assign q_pop     = load;

   // minor step test differs by major axis
   assign take = x_major_ff ? (err_ff >= 0) : (err_ff > 0);

   always_comb begin
      busy_in     = busy_ff;
      x_major_in  = x_major_ff;
      min_down_in = min_down_ff;
      maj_in      = maj_ff;
      min_in      = min_ff;
      left_in     = left_ff;
      err_in      = err_ff;
      inc_keep_in = inc_keep_ff;
      inc_take_in = inc_take_ff;
      // step to the next pixel
      if (advance) begin
         busy_in = !finishing;
         maj_in  = maj_ff + 1'b1;
         left_in = left_ff - 1'b1;
         if (take) begin
            min_in = min_down_ff ? (min_ff - 1'b1) : (min_ff + 1'b1);
            err_in = err_ff + inc_take_ff;
         end else begin
            err_in = err_ff + $signed({2'b00, inc_keep_ff});
         end
      end
      // start a new line from the queue
      if (load) begin
         busy_in     = 1'b1;
         x_major_in  = q_cmd.x_major;
         min_down_in = q_cmd.min_down;
         maj_in      = q_cmd.maj_pos;
         min_in      = q_cmd.min_pos;
         left_in     = q_cmd.span;
         err_in      = q_cmd.err;
         inc_keep_in = q_cmd.inc_keep;
         inc_take_in = q_cmd.inc_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // line state, no reset needed
   always_ff @(posedge clock) begin
      x_major_ff  <= x_major_in;
      min_down_ff <= min_down_in;
      maj_ff      <= maj_in;
      min_ff      <= min_in;
      left_ff     <= left_in;
      err_ff      <= err_in;
      inc_keep_ff <= inc_keep_in;
      inc_take_ff <= inc_take_in;
   end

   // current pixel is the result on offer
   assign rsp_empty  = !busy_ff;
   assign point_x    = x_major_ff ? maj_ff : min_ff;
   assign point_y    = x_major_ff ? min_ff : maj_ff;
   assign last_point = (left_ff == '0);

endmodule

>>> hdl/bresenham_line_stepper_core.sv
// Bresenham line stepper
// Input channel (req_*): one line command per transfer, two endpoints,
//   accepted on a clock edge with req_push high and req_full low.
// Result channel (rsp_*): one pixel per transfer, in stepping order from the
//   smaller major coordinate; rsp_last_point marks the final pixel of a line.
//   The pixel on the ports is taken on an edge with rsp_pop high and
//   rsp_empty low.
// A line with major span S yields S+1 pixels, 1 to 2**COORD_BITS.
// With the stepper idle, the command is written into the queue at its transfer
//   edge, the stepper then loads it from the queue into its line registers and
//   the first pixel is on the ports from then on. One pixel per cycle while
//   rsp_pop stays high.
// A two-entry command queue sits between setup and stepper, so new commands
//   are taken while a line is still being walked.
// If rsp_pop stays low the current pixel holds; once the queue is full,
//   req_full rises.
// Reset (synchronous, active high) empties the queue and idles the stepper.
// depends on bls_pkg, bls_setup, bls_cmd_queue, bls_stepper
module bresenham_line_stepper_core #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [COORD_BITS-1:0] rsp_point_x,
   output logic [COORD_BITS-1:0] rsp_point_y,
   output logic                  rsp_last_point
);
   import bls_pkg::*;

   localparam int CMD_W = cmd_bits(COORD_BITS);

   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_empty;
   logic [CMD_W-1:0] q_wr_word;
   logic [CMD_W-1:0] q_rd_word;

   // classify incoming commands
   bls_setup #(
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .req_push (req_push),
      .req_full (req_full),
      .start_x  (req_start_x),
      .start_y  (req_start_y),
      .end_x    (req_end_x),
      .end_y    (req_end_y),
      .q_push   (q_push),
      .q_full   (q_full),
      .cmd_word (q_wr_word)
   );

   // decouple setup from stepping
   bls_cmd_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_word),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_rd_word)
   );

   // walk the line
   bls_stepper #(
      .COORD_BITS (COORD_BITS)
   ) u_stepper (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_word     (q_rd_word),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .point_x    (rsp_point_x),
      .point_y    (rsp_point_y),
      .last_point (rsp_last_point)
   );

endmodule

>>> hdl/bls_checker.sv
// port-level checks for the line stepper, bound to the top level
// depends on bls_pkg and assert_macros.svh
`include "assert_macros.svh"

module bls_checker #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_push,
   input logic                  req_full,
   input logic [COORD_BITS-1:0] req_start_x,
   input logic [COORD_BITS-1:0] req_start_y,
   input logic [COORD_BITS-1:0] req_end_x,
   input logic [COORD_BITS-1:0] req_end_y,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [COORD_BITS-1:0] rsp_point_x,
   input logic [COORD_BITS-1:0] rsp_point_y,
   input logic                  rsp_last_point
);
   import bls_pkg::*;

   logic pix_xfer;
   assign pix_xfer = rsp_pop && !rsp_empty;

   // reset leaves no pixel pending and room for commands
   `ASSERT_PROP_NORST(a_reset_idle, clock, reset |=> (rsp_empty && !req_full), "not idle after reset")

   // a stalled pixel holds
   `ASSERT_PROP(a_stall_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_last_point)), "pixel changed while stalled")

   // inside a line the next pixel follows without a gap
   `ASSERT_PROP(a_line_no_gap, clock, reset, (pix_xfer && !rsp_last_point) |=> !rsp_empty, "gap inside a line")

   // consecutive pixels of one line are neighbors
   `ASSERT_PROP(a_line_adjacent, clock, reset, (pix_xfer && !rsp_last_point) |=> ((rsp_point_x == $past(rsp_point_x) || rsp_point_x == COORD_BITS'($past(rsp_point_x) + 1'b1) || rsp_point_x == COORD_BITS'($past(rsp_point_x) - 1'b1)) && (rsp_point_y == $past(rsp_point_y) || rsp_point_y == COORD_BITS'($past(rsp_point_y) + 1'b1) || rsp_point_y == COORD_BITS'($past(rsp_point_y) - 1'b1))), "pixels not adjacent")

endmodule

bind bresenham_line_stepper_core bls_checker #(
   .COORD_BITS (COORD_BITS)
) u_bls_checker (.*);
